// ===== rtl/npsrch_pkg.sv =====
// Package for the nearest prime search block.
// Holds the shared default width of the input number; no dependencies.
`default_nettype none

package npsrch_pkg;

    // Default width of the input number.
    localparam int NUM_WIDTH_DEF = 16;

endpackage

`default_nettype wire

// ===== rtl/npsrch_div.sv =====
// Iterative restoring divider that returns the remainder only.
// One quotient bit per cycle; depends on nothing outside this file.
`default_nettype none

module npsrch_div #(
    parameter int NW = 17,
    parameter int DW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_dvd;
    logic [DW-1:0]   r_dsr;
    logic [DW-1:0]   r_rem;

    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic [DW-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[NW-1]};
        diff  = trial - {1'b0, r_dsr};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = diff[DW-1:0];
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/nearest_prime_search.sv =====
// Top level of the nearest prime search block: sequencer and result registers.
// Depends on npsrch_pkg and on the remainder divider npsrch_div.
`default_nettype none

// The block takes one number per transfer (start high while busy is low) and
// searches, by trial division, for the largest prime below it and the
// smallest prime above it. Candidates below the number are tried downward
// from number-1, then candidates above it upward from number+1. Each
// candidate j is divided by d = 2, 3, ... while d*d <= j, one division at a
// time on a single shared restoring divider that produces one quotient bit
// per clock. Each divisor takes a test step, the divider steps over all
// NUM_WIDTH+1 bits of the candidate, and then the remainder is taken. Each
// candidate adds a setup step, and a candidate found prime adds a closing
// test step. Inputs of one and two have nothing below them to test. The
// time an item takes is set mostly by how many trial divisions the divider
// must run. A zero input is flagged as bad in the cycle right after the
// accepting edge, and the block can take the next transfer in the cycle
// after that. The result appears for exactly one cycle with o_done high,
// and the receiver cannot stall it: capture it in that cycle. busy stays
// high from the accepting edge through the o_done cycle.
module nearest_prime_search #(
    parameter int NUM_WIDTH = npsrch_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [NUM_WIDTH-1:0] i_number,
    output logic                      o_done,
    output logic [NUM_WIDTH-1:0]      o_lower_prime,
    output logic [NUM_WIDTH:0]        o_upper_prime,
    output logic [NUM_WIDTH:0]        o_nearest_prime,
    output logic                      o_is_tie,
    output logic                      o_bad_input
);

    // Candidates reach at most twice the input, so one extra bit suffices.
    localparam int CW  = NUM_WIDTH + 1;
    // Divisors stay at or below the square root of a candidate, plus one.
    localparam int DW  = (CW + 1) / 2 + 1;
    localparam int SQW = 2 * DW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic PH_LOWER = 1'b0;
    localparam logic PH_UPPER = 1'b1;

    logic [2:0]           r_state, n_state;
    logic                 r_phase, n_phase;
    logic [NUM_WIDTH-1:0] r_n, n_n;
    logic [CW-1:0]        r_j, n_j;
    logic [DW-1:0]        r_d, n_d;
    logic [SQW-1:0]       r_sq, n_sq;
    logic [NUM_WIDTH-1:0] r_lo, n_lo;
    logic [CW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_near, n_near;
    logic                 r_tie, n_tie;
    logic                 r_bad, n_bad;

    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_rem;

    logic                 sq_over;
    logic [CW-1:0]        dist_lo;
    logic [CW-1:0]        dist_hi;

    npsrch_div #(
        .NW (CW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_j),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // The running square is kept up to date by adding 2d+1 each time d steps,
    // so no multiplier is needed.
    assign sq_over   = r_sq > SQW'(r_j);
    assign div_start = (r_state == S_TEST) && !sq_over;

    assign dist_lo = CW'(r_n) - CW'(r_lo);
    assign dist_hi = r_hi - CW'(r_n);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_n     = r_n;
        n_j     = r_j;
        n_d     = r_d;
        n_sq    = r_sq;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_near  = r_near;
        n_tie   = r_tie;
        n_bad   = r_bad;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n = i_number;
                    if (i_number == '0) begin
                        // A zero input is invalid: flag it with all values clear.
                        n_lo    = '0;
                        n_hi    = '0;
                        n_near  = '0;
                        n_tie   = 1'b0;
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_phase = PH_LOWER;
                        n_j     = CW'(i_number) - CW'(1);
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (r_phase == PH_LOWER && r_j < CW'(2)) begin
                    // Nothing prime lies below the input.
                    n_lo    = '0;
                    n_phase = PH_UPPER;
                    n_j     = CW'(r_n) + CW'(1);
                end else begin
                    n_d     = DW'(2);
                    n_sq    = SQW'(4);
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (sq_over) begin
                    // No divisor found up to the square root: the candidate is prime.
                    if (r_phase == PH_LOWER) begin
                        n_lo    = r_j[NUM_WIDTH-1:0];
                        n_phase = PH_UPPER;
                        n_j     = CW'(r_n) + CW'(1);
                        n_state = S_NEXT;
                    end else begin
                        n_hi    = r_j;
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        if (r_phase == PH_LOWER) begin
                            n_j = r_j - CW'(1);
                        end else begin
                            n_j = r_j + CW'(1);
                        end
                        n_state = S_NEXT;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_sq    = r_sq + SQW'({r_d, 1'b0}) + SQW'(1);
                        n_state = S_TEST;
                    end
                end
            end
            S_FIN: begin
                n_tie = 1'b0;
                if (r_lo == '0) begin
                    n_near = r_hi;
                end else if (dist_lo == dist_hi) begin
                    n_near = CW'(r_lo);
                    n_tie  = 1'b1;
                end else if (dist_lo < dist_hi) begin
                    n_near = CW'(r_lo);
                end else begin
                    n_near = r_hi;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_LOWER;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_j    <= n_j;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_near <= n_near;
        r_tie  <= n_tie;
        r_bad  <= n_bad;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_lower_prime   = r_lo;
    assign o_upper_prime   = r_hi;
    assign o_nearest_prime = r_near;
    assign o_is_tie        = r_tie;
    assign o_bad_input     = r_bad;

endmodule

`default_nettype wire

// ===== rtl/npsrch_chk.sv =====
// Port-level checker for the nearest prime search block, with its bind.
// Depends on npsrch_pkg and on the top level nearest_prime_search.
`default_nettype none

module npsrch_chk #(
    parameter int NUM_WIDTH = npsrch_pkg::NUM_WIDTH_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire logic [NUM_WIDTH-1:0] o_lower_prime,
    input wire logic [NUM_WIDTH:0]   o_upper_prime,
    input wire logic [NUM_WIDTH:0]   o_nearest_prime,
    input wire logic                 o_is_tie,
    input wire logic                 o_bad_input
);

    // An accepted transfer makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transfer");

    // The result strobe lasts one cycle and comes only while busy.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (busy ##1 !o_done))
        else $error("result strobe not a single busy cycle");

    // A bad input clears every other result field.
    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_input) |->
            (o_lower_prime == '0 && o_upper_prime == '0 &&
             o_nearest_prime == '0 && !o_is_tie))
        else $error("bad input result carries nonzero fields");

    // The nearest prime is one of the two reported primes, lower on a tie.
    a_near_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_input) |->
            ((o_nearest_prime == {1'b0, o_lower_prime} && o_lower_prime != '0) ||
             (o_nearest_prime == o_upper_prime && !o_is_tie)))
        else $error("nearest prime is not a valid pick");

    // The upper prime always lies above the lower prime.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_input) |-> (o_upper_prime > {1'b0, o_lower_prime}))
        else $error("upper prime not above lower prime");

endmodule

bind nearest_prime_search npsrch_chk #(
    .NUM_WIDTH (NUM_WIDTH)
) u_npsrch_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_lower_prime   (o_lower_prime),
    .o_upper_prime   (o_upper_prime),
    .o_nearest_prime (o_nearest_prime),
    .o_is_tie        (o_is_tie),
    .o_bad_input     (o_bad_input)
);

`default_nettype wire

// ===== bench/nearest_prime_checker.sv =====
// Checker for the nearest prime search block: watches the number and result transfers,
// predicts each result by trial division and compares it field by field.
// Depends on npsrch_pkg for the default number width.
`timescale 1ns / 1ps

module nearest_prime_checker #(
    parameter int NW = npsrch_pkg::NUM_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire logic [NW-1:0] i_number,
    input  wire logic          o_done,
    input  wire logic [NW-1:0] o_lower_prime,
    input  wire logic [NW:0]   o_upper_prime,
    input  wire logic [NW:0]   o_nearest_prime,
    input  wire logic          o_is_tie,
    input  wire logic          o_bad_input,
    output int                 mismatch_count,
    output int                 results_pending
);

    typedef struct {
        logic [NW-1:0] lower;
        logic [NW:0]   upper;
        logic [NW:0]   nearest;
        logic          tie;
        logic          bad;
    } prime_result_t;

    prime_result_t expected_primes [$];
    int            errors = 0;

    function automatic bit has_no_divisor(input longint unsigned j);
        longint unsigned d;
        if (j < 2) return 1'b0;
        for (d = 2; d * d <= j; d++) begin
            if (j % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic prime_result_t search_primes(input logic [NW-1:0] n);
        prime_result_t   r;
        longint unsigned value;
        longint unsigned below;
        longint unsigned above;
        longint unsigned j;
        r = '{default: '0};
        value = n;
        if (value == 0) begin
            r.bad = 1'b1;
            return r;
        end
        below = 0;
        for (j = value - 1; j > 1; j--) begin
            if (has_no_divisor(j)) begin
                below = j;
                break;
            end
        end
        above = value + 1;
        while (!has_no_divisor(above)) above++;
        r.lower = below[NW-1:0];
        r.upper = above[NW:0];
        if (below == 0) begin
            r.nearest = above[NW:0];
        end else if (value - below == above - value) begin
            // Equal distance: report the lower prime and flag the tie.
            r.nearest = below[NW:0];
            r.tie     = 1'b1;
        end else begin
            r.nearest = (value - below < above - value) ? below[NW:0] : above[NW:0];
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [NW:0] want,
                               input logic [NW:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // Outputs are sampled at the edge that ends the strobe cycle, so the values seen
    // here are the ones held before the edge.
    always @(posedge i_clk) begin
        prime_result_t want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_primes.size() == 0) begin
                    $display("%0t: result with no number outstanding, expected none, actual %0d",
                             $time, o_nearest_prime);
                    errors++;
                end else begin
                    want = expected_primes.pop_front();
                    check_field("lower_prime", {1'b0, want.lower}, {1'b0, o_lower_prime});
                    check_field("upper_prime", want.upper, o_upper_prime);
                    check_field("nearest_prime", want.nearest, o_nearest_prime);
                    check_field("is_tie", {{NW{1'b0}}, want.tie}, {{NW{1'b0}}, o_is_tie});
                    check_field("bad_input", {{NW{1'b0}}, want.bad}, {{NW{1'b0}}, o_bad_input});
                end
            end
            if (start && busy === 1'b0) expected_primes.push_back(search_primes(i_number));
        end
        mismatch_count  <= errors;
        results_pending <= expected_primes.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the nearest prime search bench: clock, reset, number stimulus and verdict.
// Depends on npsrch_pkg, the nearest_prime_search block and nearest_prime_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int NW           = npsrch_pkg::NUM_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 100;
    // Cycles with neither a number nor a result transfer before the run is abandoned.
    localparam int STALL_LIMIT  = 400000;
    // Quiet time after the last result, long enough to catch a stray result.
    localparam int DRAIN_CYCLES = 2000;

    logic          i_clk    = 1'b0;
    logic          i_rst_n  = 1'b0;
    logic          start    = 1'b0;
    logic [NW-1:0] i_number = '0;
    logic          busy;
    logic          o_done;
    logic [NW-1:0] o_lower_prime;
    logic [NW:0]   o_upper_prime;
    logic [NW:0]   o_nearest_prime;
    logic          o_is_tie;
    logic          o_bad_input;

    int mismatch_count;
    int results_pending;
    int idle_cycles = 0;
    bit burst_mode  = 1'b0;

    nearest_prime_search #(
        .NUM_WIDTH(NW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_number       (i_number),
        .o_done         (o_done),
        .o_lower_prime  (o_lower_prime),
        .o_upper_prime  (o_upper_prime),
        .o_nearest_prime(o_nearest_prime),
        .o_is_tie       (o_is_tie),
        .o_bad_input    (o_bad_input)
    );

    nearest_prime_checker #(
        .NW(NW)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_number       (i_number),
        .o_done         (o_done),
        .o_lower_prime  (o_lower_prime),
        .o_upper_prime  (o_upper_prime),
        .o_nearest_prime(o_nearest_prime),
        .o_is_tie       (o_is_tie),
        .o_bad_input    (o_bad_input),
        .mismatch_count (mismatch_count),
        .results_pending(results_pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("nearest_prime_search test failed");
            $finish;
        end
    end

    // Present a number and hold it until the block takes it.
    task automatic offer_number(input logic [NW-1:0] value);
        i_number <= value;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // The pending count is registered, so it is read after its register has taken the last transfer.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Mostly small numbers, since search time grows with the square root of the
    // candidates; twelve in a hundred span the whole range so every input bit toggles.
    function automatic logic [NW-1:0] random_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 63) return NW'($urandom_range(1, 1023));
        if (r < 88) return NW'($urandom_range(1024, 16383));
        return NW'($urandom_range(0, (1 << NW) - 1));
    endfunction

    initial begin
        logic [NW-1:0] corner_numbers [$];
        // Zero (twice, back to back), no lower prime, ties, a prime input, the
        // widest known prime gap below 2^16, bit patterns, and the top of the
        // range where the upper prime needs the extra output bit.
        corner_numbers = '{16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8,
                           16'd9, 16'd10, 16'd24, 16'd97, 16'd120, 16'd1000,
                           16'd31433, 16'h5555, 16'hAAAA, 16'h8000, 16'd65520,
                           16'd65521, 16'd65534, 16'hFFFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_numbers[k]) begin
            offer_number(corner_numbers[k]);
            if (k == 8) hold_off(random_gap());
        end
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Every twenty items, sometimes run a stretch with no sender gaps.
            if (i % 20 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            offer_number(random_number());
            if ($urandom_range(0, 9) == 0) begin
                wait_for_results();
            end else begin
                hold_off(random_gap());
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("nearest_prime_search test passed");
        end else begin
            $display("nearest_prime_search test failed");
        end
        $finish;
    end

endmodule
